/* sv/assert_macros.svh */
// Assertion macros used by the timer event core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is high.
`define TEDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define TEDPC_ASSERT_IMP(lbl, ante, cons, msg) \
  `TEDPC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* sv/tedpc_pkg.sv */
// Types and constants of the timer event, DAC pattern and pulse capture core.
package tedpc_pkg;

  // Width of the measured time values and of the overflow counter.
  localparam int unsigned TIME_W = 32;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned TICKS_W = 17;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned OUT_TIME_W = 32;

  localparam logic [STEP_W-1:0] PATTERN_ZEROS = STEP_W'(5);
  localparam logic [STEP_W-1:0] PATTERN_LEN   = STEP_W'(10);

  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(100);

  typedef enum logic [MODE_W-1:0] {
    MODE_PATTERN     = 2'd0,
    MODE_PASSTHROUGH = 2'd1,
    MODE_SAMPLE_REQ  = 2'd2,
    MODE_PULSE_MEAS  = 2'd3
  } mode_e;

  // APB register indexes (byte address divided by four).
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_TICKS = 1'b1;

  typedef struct packed {
    logic                overflow_event;
    logic                capture_event;
    logic [COUNT_W-1:0]  capture_count;
    logic [SAMPLE_W-1:0] adc_sample;
    logic                rearm;
  } item_t;

  typedef struct packed {
    logic                  dac_write;
    logic [SAMPLE_W-1:0]   dac_value;
    logic                  sample_request;
    logic                  restart_counter;
    logic                  watch_falling_edge;
    logic [OUT_TIME_W-1:0] high_time;
    logic [OUT_TIME_W-1:0] low_time;
    logic                  measure_done;
  } result_t;

  typedef struct packed {
    logic [STEP_W-1:0] pattern_step;
    logic [TIME_W-1:0] overflow_count;
    logic              started;
    logic              done;
    logic              low_phase;
    logic              polarity_falling;
    logic [TIME_W-1:0] high_hold;
    logic [TIME_W-1:0] low_hold;
  } state_t;

endpackage

/* sv/tedpc_ifs.sv */
// Valid/ready channel interfaces for timer events and for results.
interface tedpc_evt_if;
  logic                              valid;
  logic                              ready;
  logic                              overflow_event;
  logic                              capture_event;
  logic [tedpc_pkg::COUNT_W-1:0]     capture_count;
  logic [tedpc_pkg::SAMPLE_W-1:0]    adc_sample;
  logic                              rearm;

  modport source (output valid, overflow_event, capture_event, capture_count, adc_sample,
                  rearm, input ready);
  modport sink (input valid, overflow_event, capture_event, capture_count, adc_sample,
                rearm, output ready);
endinterface

interface tedpc_res_if;
  logic                              valid;
  logic                              ready;
  logic                              dac_write;
  logic [tedpc_pkg::SAMPLE_W-1:0]    dac_value;
  logic                              sample_request;
  logic                              restart_counter;
  logic                              watch_falling_edge;
  logic [tedpc_pkg::OUT_TIME_W-1:0]  high_time;
  logic [tedpc_pkg::OUT_TIME_W-1:0]  low_time;
  logic                              measure_done;

  modport source (output valid, dac_write, dac_value, sample_request, restart_counter,
                  watch_falling_edge, high_time, low_time, measure_done, input ready);
  modport sink (input valid, dac_write, dac_value, sample_request, restart_counter,
                watch_falling_edge, high_time, low_time, measure_done, output ready);
endinterface

/* sv/tedpc_step.sv */
// Next-state and result logic for one timer event.
module tedpc_step (
  input  tedpc_pkg::mode_e                    mode_i,
  input  logic [tedpc_pkg::TICKS_W-1:0]       ticks_i,
  input  tedpc_pkg::state_t                   state_i,
  input  tedpc_pkg::item_t                    item_i,
  output tedpc_pkg::state_t                   state_o,
  output tedpc_pkg::result_t                  result_o
);

  localparam int unsigned ProdW = tedpc_pkg::TIME_W + tedpc_pkg::TICKS_W;

  logic                             started_r;
  logic                             done_r;
  logic                             handled;
  logic [tedpc_pkg::TIME_W-1:0]     count_n;
  logic [ProdW-1:0]                 product;
  logic [tedpc_pkg::TIME_W-1:0]     meas_time;
  tedpc_pkg::state_t                st;
  tedpc_pkg::result_t               res;

  // Rearm takes effect before the event itself is looked at.
  assign started_r = state_i.started & ~item_i.rearm;
  assign done_r    = state_i.done & ~item_i.rearm;
  assign handled   = item_i.overflow_event | item_i.capture_event;

  // A simultaneous overflow is counted before the capture is measured.
  assign count_n = (item_i.overflow_event && started_r) ?
                   state_i.overflow_count + tedpc_pkg::TIME_W'(1) : state_i.overflow_count;
  assign product   = ProdW'(count_n) * ProdW'(ticks_i);
  assign meas_time = product[tedpc_pkg::TIME_W-1:0] +
                     tedpc_pkg::TIME_W'(item_i.capture_count);

  always_comb begin
    st         = state_i;
    st.started = started_r;
    st.done    = done_r;
    res        = '0;
    if (handled) begin
      case (mode_i)
        tedpc_pkg::MODE_PATTERN: begin
          if (state_i.pattern_step < tedpc_pkg::PATTERN_ZEROS) begin
            res.dac_write   = 1'b1;
            st.pattern_step = state_i.pattern_step + tedpc_pkg::STEP_W'(1);
          end else if (state_i.pattern_step <
                       tedpc_pkg::PATTERN_LEN - tedpc_pkg::STEP_W'(1)) begin
            res.dac_write   = 1'b1;
            res.dac_value   = item_i.adc_sample;
            st.pattern_step = state_i.pattern_step + tedpc_pkg::STEP_W'(1);
          end else begin
            st.pattern_step = '0;
          end
        end
        tedpc_pkg::MODE_PASSTHROUGH: begin
          res.dac_write = 1'b1;
          res.dac_value = item_i.adc_sample;
        end
        tedpc_pkg::MODE_SAMPLE_REQ: begin
          res.sample_request = 1'b1;
        end
        default: begin
          if (!done_r) begin
            st.overflow_count = count_n;
            if (item_i.capture_event) begin
              st.overflow_count = '0;
              if (!started_r) begin
                st.started          = 1'b1;
                st.low_phase        = 1'b0;
                st.polarity_falling = 1'b1;
                res.restart_counter = 1'b1;
              end else if (!state_i.low_phase) begin
                st.high_hold        = meas_time;
                st.low_phase        = 1'b1;
                st.polarity_falling = 1'b0;
                res.restart_counter = 1'b1;
              end else begin
                st.low_hold  = meas_time;
                st.low_phase = 1'b0;
                st.done      = 1'b1;
              end
            end
          end
        end
      endcase
    end
    res.watch_falling_edge = st.polarity_falling;
    res.high_time          = tedpc_pkg::OUT_TIME_W'(st.high_hold);
    res.low_time           = tedpc_pkg::OUT_TIME_W'(st.low_hold);
    res.measure_done       = st.done;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

/* sv/timer_event_dac_and_pulse_capture_core.sv */
// Top level of the timer event core: DAC pattern, passthrough, sample request and pulse capture.
// Each timer event arrives as one transaction on evt_i and produces exactly one
// result transaction on res_o. A transaction is first held in an input register;
// from there the event logic (one 32 x 17 multiply for the measured time, plus
// a handful of flags) writes the state registers and the result register in the
// same cycle, so a result is offered on res_o once its event has moved on from the
// input register into the result register. One event is accepted every cycle as
// long as results are drained, because the only feedback path is the state
// register loop through the overflow counter and the multiplier. The input and
// result registers form a two-deep pipeline: while a result waits for res_o.ready
// the next event is still taken into an empty input register. Software
// sets the operating mode and the ticks-per-overflow period over the APB port
// (byte addresses 0 and 4); these registers should only be written while no
// event is in flight.
module timer_event_dac_and_pulse_capture_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  tedpc_evt_if.sink         evt_i,
  tedpc_res_if.source       res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "assert_macros.svh"

  // Configuration registers.
  tedpc_pkg::mode_e                mode_q;
  logic [tedpc_pkg::TICKS_W-1:0]   ticks_q;
  logic                            cfg_wr;

  // Pipeline registers and block state.
  logic                            in_valid_q;
  tedpc_pkg::item_t                in_item_q;
  logic                            res_valid_q;
  tedpc_pkg::result_t              res_q;
  tedpc_pkg::state_t               state_q;
  tedpc_pkg::state_t               state_d;
  tedpc_pkg::result_t              res_d;
  logic                            advance;
  logic                            evt_take;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tedpc_pkg::MODE_PATTERN;
      ticks_q <= tedpc_pkg::TICKS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        tedpc_pkg::REG_MODE:  mode_q  <= tedpc_pkg::mode_e'(pwdata[tedpc_pkg::MODE_W-1:0]);
        tedpc_pkg::REG_TICKS: ticks_q <= pwdata[tedpc_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tedpc_pkg::REG_MODE:  prdata = 32'(mode_q);
      tedpc_pkg::REG_TICKS: prdata = 32'(ticks_q);
      default:              prdata = '0;
    endcase
  end

  // The held event moves on whenever the result register is free or is being
  // emptied this cycle; a new event enters whenever the input register is empty or moves on.
  assign advance     = in_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign evt_take    = evt_i.valid && evt_i.ready;

  tedpc_step u_step (
    .mode_i   (mode_q),
    .ticks_i  (ticks_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (evt_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset: their valid flags guard them.
  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      in_item_q.overflow_event <= evt_i.overflow_event;
      in_item_q.capture_event  <= evt_i.capture_event;
      in_item_q.capture_count  <= evt_i.capture_count;
      in_item_q.adc_sample     <= evt_i.adc_sample;
      in_item_q.rearm          <= evt_i.rearm;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.dac_write          = res_q.dac_write;
  assign res_o.dac_value          = res_q.dac_value;
  assign res_o.sample_request     = res_q.sample_request;
  assign res_o.restart_counter    = res_q.restart_counter;
  assign res_o.watch_falling_edge = res_q.watch_falling_edge;
  assign res_o.high_time          = res_q.high_time;
  assign res_o.low_time           = res_q.low_time;
  assign res_o.measure_done       = res_q.measure_done;

  // An empty result register must never hold back the event channel.
  `TEDPC_ASSERT_IMP(a_ready_when_res_free, !res_valid_q, evt_i.ready,
                    "event stalled with free result register")
  // A finished measurement always belongs to a started one.
  `TEDPC_ASSERT_IMP(a_done_implies_started, state_q.done, state_q.started, "done without started")
  // The pattern counter never leaves its ten steps.
  `TEDPC_ASSERT(a_pattern_in_range, state_q.pattern_step < tedpc_pkg::PATTERN_LEN,
                "pattern step out of range")
  // A silent DAC cycle carries a zero value.
  `TEDPC_ASSERT_IMP(a_dac_zero_when_idle, res_valid_q && !res_q.dac_write,
                    res_q.dac_value == '0, "DAC value without write")

endmodule
